// ===== rtl/lc3_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lc3_pkg
// Shared constants, types and helpers for the LC-3 subset step unit.
// ----------------------------------------------------------------------------
package lc3_pkg;

    localparam int unsigned MEM_WORDS = 1024;
    localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);
    localparam int unsigned REG_AW    = 3;

    typedef logic [15:0]       t_word;
    typedef logic [MEM_AW-1:0] t_maddr;
    typedef logic [REG_AW-1:0] t_ridx;
    typedef logic [2:0]        t_cc;

    // item commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EXEC = 1'b1;

    // opcodes, ir[15:12]
    localparam logic [3:0] OP_BR   = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_LD   = 4'd2;
    localparam logic [3:0] OP_ST   = 4'd3;
    localparam logic [3:0] OP_AND  = 4'd5;
    localparam logic [3:0] OP_NOT  = 4'd9;
    localparam logic [3:0] OP_JMP  = 4'd12;
    localparam logic [3:0] OP_TRAP = 4'd15;

    localparam t_ridx      LINK_REG    = 3'd7;
    localparam logic [7:0] HALT_VECTOR = 8'h25;

    localparam t_cc CC_N = 3'b100;
    localparam t_cc CC_Z = 3'b010;
    localparam t_cc CC_P = 3'b001;

    function automatic t_cc cond_of(input t_word v);
        t_cc c;
        if (v[15]) begin
            c = CC_N;
        end else if (v == 16'h0000) begin
            c = CC_Z;
        end else begin
            c = CC_P;
        end
        return c;
    endfunction

    function automatic t_word sext9(input logic [8:0] v);
        return {{7{v[8]}}, v};
    endfunction

    function automatic t_word sext5(input logic [4:0] v);
        return {{11{v[4]}}, v};
    endfunction

endpackage

// ===== rtl/lc3_subset_core_step_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lc3_subset_core_step_unit
// LC-3 subset core, one instruction or one program word load per item.
// ----------------------------------------------------------------------------
// Each input transfer is either a load item (writes one memory word, clears
// halt) or an execute item (runs one instruction: ADD, AND, NOT, LD, ST, BR,
// JMP, TRAP; TRAP x25 halts). Every item yields exactly one result transfer.
// Main memory is one single-port-write, single-read synchronous RAM of
// MEM_WORDS words; the eight general registers sit in a small RAM with two
// registered read ports. An executed instruction goes from transfer to
// registered result through fetch read at PC, decode with the data or
// trap-vector read plus operand reads, then execute and write-back. Load items
// and execute items while halted go from transfer straight to the response
// step. The next item is taken the cycle after the result is registered, so
// the core takes no new item before the last one is through.
// The result sits in an output register, so the core accepts the next item
// while the previous result still waits; it stalls only in its final step if
// that register is still full. After reset the core runs a clearing pass over
// all MEM_WORDS (1024) addresses that zeroes memory and registers; o_in_ready
// stays low until it ends. Memory accesses of one item are in distinct
// cycles and items do not overlap, so no forwarding is needed.
// ----------------------------------------------------------------------------
module lc3_subset_core_step_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [9:0]  i_load_addr,
    input  logic [15:0] i_load_data,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_pc_out,
    output logic [15:0] o_ir_out,
    output logic [2:0]  o_cc_out,
    output logic        o_halted_out,
    output logic        o_reg_wr_valid,
    output logic [2:0]  o_reg_wr_index,
    output logic [15:0] o_reg_wr_value,
    output logic        o_mem_wr_valid
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_EXEC,
        S_RESP
    } t_state;

    // ---------------- state ----------------
    t_state             r_state, n_state;
    logic               r_clr_busy, n_clr_busy;
    lc3_pkg::t_maddr    r_clr_cnt, n_clr_cnt;
    lc3_pkg::t_word     r_pc, n_pc;
    lc3_pkg::t_word     r_ir, n_ir;
    lc3_pkg::t_cc       r_cc, n_cc;
    logic               r_halt, n_halt;
    lc3_pkg::t_word     r_ea, n_ea;

    // registered RAM read data
    lc3_pkg::t_word     r_mem_rd;
    lc3_pkg::t_word     r_rf_a;
    lc3_pkg::t_word     r_rf_b;

    // result register
    logic               r_out_valid, n_out_valid;
    lc3_pkg::t_word     r_out_pc;
    lc3_pkg::t_word     r_out_ir;
    lc3_pkg::t_cc       r_out_cc;
    logic               r_out_halt;
    logic               r_out_rwv;
    lc3_pkg::t_ridx     r_out_ridx;
    lc3_pkg::t_word     r_out_rval;
    logic               r_out_mwv;

    // ---------------- storage ----------------
    lc3_pkg::t_word     mem [lc3_pkg::MEM_WORDS];
    lc3_pkg::t_word     rf  [2**lc3_pkg::REG_AW];

    // ---------------- handshake ----------------
    logic in_xfer;
    logic out_free;
    logic post;          // result register loads this cycle
    logic exec_fire;     // execute step completes this cycle

    assign o_in_ready = !r_clr_busy && (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign exec_fire  = (r_state == S_EXEC) && out_free;

    // ---------------- decode step ----------------
    // r_mem_rd holds the fetched word during S_DECODE.
    logic [3:0]      dec_op;
    lc3_pkg::t_word  dec_pc1;
    lc3_pkg::t_word  dec_ea;
    lc3_pkg::t_maddr dec_addr;
    lc3_pkg::t_ridx  dec_sra;
    lc3_pkg::t_ridx  dec_srb;

    always_comb begin
        dec_op  = r_mem_rd[15:12];
        dec_pc1 = r_pc + 16'd1;
        dec_ea  = dec_pc1 + lc3_pkg::sext9(r_mem_rd[8:0]);
        dec_sra = r_mem_rd[8:6];
        // ST reads its source from the DR field
        dec_srb = (dec_op == lc3_pkg::OP_ST) ? r_mem_rd[11:9] : r_mem_rd[2:0];
        // LD reads data at the effective address, otherwise the trap vector
        if (dec_op == lc3_pkg::OP_LD) begin
            dec_addr = dec_ea[lc3_pkg::MEM_AW-1:0];
        end else begin
            dec_addr = lc3_pkg::t_maddr'({8'h00, r_mem_rd[7:0]});
        end
    end

    // ---------------- execute step ----------------
    logic [3:0]     ex_op;
    lc3_pkg::t_ridx ex_dr;
    lc3_pkg::t_word ex_opb;
    logic           ex_wr;
    lc3_pkg::t_ridx ex_idx;
    lc3_pkg::t_word ex_val;
    logic           ex_st;
    lc3_pkg::t_word ex_pc;
    logic           ex_halt;
    lc3_pkg::t_cc   ex_cc;

    always_comb begin
        ex_op   = r_ir[15:12];
        ex_dr   = r_ir[11:9];
        ex_opb  = r_ir[5] ? lc3_pkg::sext5(r_ir[4:0]) : r_rf_b;
        ex_wr   = 1'b0;
        ex_idx  = '0;
        ex_val  = '0;
        ex_st   = 1'b0;
        ex_pc   = r_pc;
        ex_halt = r_halt;
        unique case (ex_op)
            lc3_pkg::OP_ADD: begin
                ex_wr  = 1'b1;
                ex_idx = ex_dr;
                ex_val = r_rf_a + ex_opb;
            end
            lc3_pkg::OP_AND: begin
                ex_wr  = 1'b1;
                ex_idx = ex_dr;
                ex_val = r_rf_a & ex_opb;
            end
            lc3_pkg::OP_NOT: begin
                ex_wr  = 1'b1;
                ex_idx = ex_dr;
                ex_val = ~r_rf_a;
            end
            lc3_pkg::OP_LD: begin
                ex_wr  = 1'b1;
                ex_idx = ex_dr;
                ex_val = r_mem_rd;
            end
            lc3_pkg::OP_ST: begin
                ex_st = 1'b1;
            end
            lc3_pkg::OP_BR: begin
                if ((ex_dr & r_cc) != 3'b000) begin
                    ex_pc = r_ea;
                end
            end
            lc3_pkg::OP_JMP: begin
                ex_pc = r_rf_a;
            end
            lc3_pkg::OP_TRAP: begin
                ex_wr  = 1'b1;
                ex_idx = lc3_pkg::LINK_REG;
                ex_val = r_pc;
                if (r_ir[7:0] == lc3_pkg::HALT_VECTOR) begin
                    ex_pc   = '0;
                    ex_halt = 1'b1;
                end else begin
                    ex_pc = r_mem_rd;
                end
            end
            default: begin
            end
        endcase
        // TRAP links R7 but leaves the condition code alone
        if (ex_wr && (ex_op != lc3_pkg::OP_TRAP)) begin
            ex_cc = lc3_pkg::cond_of(ex_val);
        end else begin
            ex_cc = r_cc;
        end
    end

    // ---------------- main memory ports ----------------
    logic            mem_we;
    lc3_pkg::t_maddr mem_waddr;
    lc3_pkg::t_word  mem_wdata;
    logic            mem_re;
    lc3_pkg::t_maddr mem_raddr;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr_cnt;
        mem_wdata = '0;
        priority if (r_clr_busy) begin
            mem_we = 1'b1;
        end else if (exec_fire && ex_st) begin
            mem_we    = 1'b1;
            mem_waddr = r_ea[lc3_pkg::MEM_AW-1:0];
            mem_wdata = r_rf_b;
        end else if (in_xfer && (i_cmd == lc3_pkg::CMD_LOAD)) begin
            mem_we    = 1'b1;
            mem_waddr = lc3_pkg::t_maddr'(i_load_addr);
            mem_wdata = i_load_data;
        end else begin
        end
        mem_re    = (r_state == S_DECODE) ||
                    (in_xfer && (i_cmd == lc3_pkg::CMD_EXEC) && !r_halt);
        mem_raddr = (r_state == S_DECODE) ? dec_addr : r_pc[lc3_pkg::MEM_AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_rd <= mem[mem_raddr];
        end
    end

    // ---------------- register file ports ----------------
    logic           rf_we;
    lc3_pkg::t_ridx rf_waddr;
    lc3_pkg::t_word rf_wdata;

    assign rf_we    = r_clr_busy || (exec_fire && ex_wr);
    assign rf_waddr = r_clr_busy ? r_clr_cnt[lc3_pkg::REG_AW-1:0] : ex_idx;
    assign rf_wdata = r_clr_busy ? '0 : ex_val;

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            rf[rf_waddr] <= rf_wdata;
        end
        if (r_state == S_DECODE) begin
            r_rf_a <= rf[dec_sra];
            r_rf_b <= rf[dec_srb];
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state    = r_state;
        n_clr_busy = r_clr_busy;
        n_clr_cnt  = r_clr_cnt;
        n_pc       = r_pc;
        n_ir       = r_ir;
        n_cc       = r_cc;
        n_halt     = r_halt;
        n_ea       = r_ea;
        post       = 1'b0;

        if (r_clr_busy) begin
            n_clr_cnt = r_clr_cnt + 1'b1;
            if (r_clr_cnt == lc3_pkg::t_maddr'(lc3_pkg::MEM_WORDS - 1)) begin
                n_clr_busy = 1'b0;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_cmd == lc3_pkg::CMD_LOAD) begin
                        n_halt  = 1'b0;
                        n_state = S_RESP;
                    end else if (r_halt) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_DECODE;
                    end
                end
            end
            S_DECODE: begin
                n_ir    = r_mem_rd;
                n_pc    = dec_pc1;
                n_ea    = dec_ea;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    n_pc    = ex_pc;
                    n_cc    = ex_cc;
                    n_halt  = ex_halt;
                    post    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    post    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (post) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clr_busy  <= 1'b1;
            r_clr_cnt   <= '0;
            r_pc        <= '0;
            r_ir        <= '0;
            r_cc        <= '0;
            r_halt      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_busy  <= n_clr_busy;
            r_clr_cnt   <= n_clr_cnt;
            r_pc        <= n_pc;
            r_ir        <= n_ir;
            r_cc        <= n_cc;
            r_halt      <= n_halt;
            r_out_valid <= n_out_valid;
        end
        r_ea <= n_ea;
        if (post) begin
            r_out_pc   <= n_pc;
            r_out_ir   <= n_ir;
            r_out_cc   <= n_cc;
            r_out_halt <= n_halt;
            // write flags only come from an executed instruction
            r_out_rwv  <= exec_fire && ex_wr;
            r_out_ridx <= exec_fire ? ex_idx : '0;
            r_out_rval <= exec_fire ? ex_val : '0;
            r_out_mwv  <= exec_fire && ex_st;
        end
    end

    // ---------------- outputs ----------------
    assign o_out_valid    = r_out_valid;
    assign o_pc_out       = r_out_pc;
    assign o_ir_out       = r_out_ir;
    assign o_cc_out       = r_out_cc;
    assign o_halted_out   = r_out_halt;
    assign o_reg_wr_valid = r_out_rwv;
    assign o_reg_wr_index = r_out_ridx;
    assign o_reg_wr_value = r_out_rval;
    assign o_mem_wr_valid = r_out_mwv;

endmodule

// ===== rtl/lc3_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lc3_chk
// Port-level checks for the LC-3 subset step unit, bound to the top level.
// ----------------------------------------------------------------------------
module lc3_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_pc_out,
    input logic [2:0]  o_reg_wr_index,
    input logic [15:0] o_reg_wr_value,
    input logic        o_reg_wr_valid,
    input logic        o_halted_out,
    input logic        o_mem_wr_valid
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_pc_out) && $stable(o_reg_wr_value))
        else $error("result changed while stalled");

    // one item in flight at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while one is in flight");

    // a register write and a memory write never come from the same step
    a_wr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_reg_wr_valid && o_mem_wr_valid))
        else $error("register and memory write in one step");

    // a result without a register write reports a zero index and value
    a_wr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_reg_wr_valid |->
            (o_reg_wr_index == 3'd0) && (o_reg_wr_value == 16'h0000))
        else $error("write fields set without a register write");

    // a write seen while halted can only be the halt trap link
    a_halt_trap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_halted_out && o_reg_wr_valid |->
            (o_reg_wr_index == lc3_pkg::LINK_REG) && (o_pc_out == 16'h0000))
        else $error("halt result without link write to R7 and PC zero");

endmodule

bind lc3_subset_core_step_unit lc3_chk u_lc3_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_pc_out       (o_pc_out),
    .o_reg_wr_index (o_reg_wr_index),
    .o_reg_wr_value (o_reg_wr_value),
    .o_reg_wr_valid (o_reg_wr_valid),
    .o_halted_out   (o_halted_out),
    .o_mem_wr_valid (o_mem_wr_valid)
);
